// ----- rtl/indexed_list_store_defines.svh -----
// ----------------------------------------------------------------------------
// indexed_list_store_defines
// Assertion macros used by the checker file of the list store.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// same-cycle implication, idle during reset
`define ILS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list store check failed");

// next-cycle implication, idle during reset
`define ILS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list store check failed");

`endif

// ----- rtl/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_SET    = 2'd3
  } ils_action_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;
    logic rem_en;
    logic set_en;
  } ils_ctrl_t;

endpackage

// ----- rtl/ils_cell.sv -----
// ----------------------------------------------------------------------------
// ils_cell
// One slot of the list: takes its lower neighbor on insert, its upper
// neighbor on remove, the write word at its own position, and drives its
// word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int ITEM_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                   clk,
  input  ils_pkg::ils_ctrl_t     ctrl,
  input  logic [ils_pkg::POS_W-1:0] position,
  input  logic [ITEM_WIDTH-1:0]  wdata,
  input  logic [ITEM_WIDTH-1:0]  lower,
  input  logic [ITEM_WIDTH-1:0]  upper,
  output logic [ITEM_WIDTH-1:0]  value,
  output logic [ITEM_WIDTH-1:0]  rd
);
  import ils_pkg::*;

  logic at_pos;
  logic above_pos;
  logic [ITEM_WIDTH-1:0] value_next;

  assign at_pos    = (int'(position) == INDEX);
  assign above_pos = (INDEX > int'(position));
  assign rd        = at_pos ? value : '0;

  always_comb begin
    value_next = value;
    if (ctrl.ins_en) begin
      if (at_pos) value_next = wdata;
      else if (above_pos) value_next = lower;
    end else if (ctrl.rem_en) begin
      if (at_pos || above_pos) value_next = upper;
    end else if (ctrl.set_en && at_pos) begin
      value_next = wdata;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- rtl/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to DEPTH words in a chain of slot cells that shift
// together on insert and remove; get and set address one cell.
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, low bit first)
//  s_      | in  | action[1:0] position[6:2] item_value[38:7]
//  m_      | out | ok[0] read_value[32:1] item_count[37:33]
//
//  One transaction per cycle unless m_ stalls; each result is valid in the next cycle.
//  The result register is the only stage: a new request enters whenever the
//  register is empty or is being taken in the same cycle.
//  Reset clears the count and the result valid; slot contents are not reset.
//  A stall on m_ holds the result and blocks s_ until it is taken.
module indexed_list_store #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // action, position, item_value, zero pad
  input  logic [ils_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // ok, read_value, item_count, zero pad
  output logic [ils_pkg::OUT_W-1:0] m_tdata
);
  import ils_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = (ITEM_WIDTH < VALUE_W) ? ITEM_WIDTH : VALUE_W;

  logic              accept;
  ils_action_t       action;
  logic [POS_W-1:0]  position;
  logic [VALUE_W-1:0] item_value;
  logic [ITEM_WIDTH-1:0] wdata;
  logic [ITEM_WIDTH-1:0] cell_value [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_rd [DEPTH];
  logic [ITEM_WIDTH-1:0] rd_all;
  logic [VALUE_W-1:0] rd_word;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              pos_lt;
  logic              pos_le;
  logic              full;
  logic              ok;
  ils_ctrl_t         ctrl;
  logic [OUT_W-1:0]  result_word;

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign action     = ils_action_t'(s_tdata[ACTION_W-1:0]);
  assign position   = s_tdata[ACTION_W +: POS_W];
  assign item_value = s_tdata[ACTION_W + POS_W +: VALUE_W];

  assign pos_lt = int'(position) <  int'(count);
  assign pos_le = int'(position) <= int'(count);
  assign full   = int'(count) == DEPTH;

  always_comb begin
    wdata = '0;
    wdata[VW-1:0] = item_value[VW-1:0];
  end

  always_comb begin
    ctrl       = '0;
    ok         = 1'b0;
    count_next = count;
    unique case (action)
      ACT_INSERT: begin
        ok = pos_le && !full;
        ctrl.ins_en = accept && ok;
        if (ok) count_next = count + CW'(1);
      end
      ACT_REMOVE: begin
        ok = pos_lt;
        ctrl.rem_en = accept && ok;
        if (ok) count_next = count - CW'(1);
      end
      ACT_GET: begin
        ok = pos_lt;
      end
      ACT_SET: begin
        ok = pos_lt;
        ctrl.set_en = accept && ok;
      end
      default: ok = 1'b0;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] lower;
    logic [ITEM_WIDTH-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_value[i+1];
    end
    ils_cell #(
      .ITEM_WIDTH (ITEM_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .position (position),
      .wdata    (wdata),
      .lower    (lower),
      .upper    (upper),
      .value    (cell_value[i]),
      .rd       (cell_rd[i])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_all = rd_all | cell_rd[i];
    end
    rd_word = '0;
    if (action == ACT_GET && ok) rd_word[VW-1:0] = rd_all[VW-1:0];
  end

  always_comb begin
    result_word = '0;
    result_word[0] = ok;
    result_word[1 +: VALUE_W] = rd_word;
    result_word[1 + VALUE_W +: COUNT_W] = COUNT_W'({{COUNT_W{1'b0}}, count_next});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) count <= count_next;
      if (accept) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_word;
    end
  end

endmodule

// ----- rtl/ils_checker.sv -----
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the list store, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_store_defines.svh"

module ils_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [ils_pkg::OUT_W-1:0] m_tdata
);
  import ils_pkg::*;

  `ILS_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ILS_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
  `ILS_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid)
  `ILS_ASSERT_NOW(a_fail_reads_zero, m_tvalid && !m_tdata[0], m_tdata[VALUE_W:1] == '0)

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

// ----- verif/tb_indexed_list_store.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Drives list requests (insert, remove, get, set) into the store and checks
// every result against a shadow copy of the list kept in the testbench.
// Directed checks cover the empty list, each insert form, first and last
// removal, out-of-range positions and a full store; random traffic sweeps
// the list between empty and full under several idle/stall mixes, including
// a long output hold-off.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int DEPTH        = 16;
  localparam int ITEM_WIDTH   = 32;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_GAP      = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] item_count;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // shadow list
  logic [VALUE_W-1:0] shadow_slots [DEPTH];
  int                 shadow_count = 0;

  list_result_t expected_results [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;

  int fail_count     = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int rejects        = 0;
  int full_rejects   = 0;
  int deepest        = 0;
  int idle_cycles    = 0;

  indexed_list_store #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic list_result_t apply_list_request(ils_action_t act,
                                                      logic [POS_W-1:0] pos,
                                                      logic [VALUE_W-1:0] val);
    list_result_t r;
    int           i;
    r = '0;
    case (act)
      ACT_INSERT: begin
        if (pos <= shadow_count && shadow_count < DEPTH) begin
          for (i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[pos] = val;
          shadow_count++;
          r.ok = 1'b1;
        end else if (shadow_count == DEPTH) begin
          full_rejects++;
        end
      end
      ACT_REMOVE: begin
        if (pos < shadow_count) begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      ACT_GET: begin
        if (pos < shadow_count) begin
          r.read_value = shadow_slots[pos];
          r.ok = 1'b1;
        end
      end
      default: begin
        if (pos < shadow_count) begin
          shadow_slots[pos] = val;
          r.ok = 1'b1;
        end
      end
    endcase
    r.item_count = COUNT_W'(shadow_count);
    if (!r.ok) rejects++;
    if (shadow_count > deepest) deepest = shadow_count;
    return r;
  endfunction

  task automatic send_request(input ils_action_t act, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, val, pos, act};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(apply_list_request(act, pos, val));
    requests_sent++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // well-formed requests with random content, sweeping between empty and full;
  // a fraction are noise with a random action and a position from 0 to 16
  task automatic run_list_traffic(input int n_items);
    bit               growing;
    int               roll;
    int               k;
    ils_action_t      act;
    logic [POS_W-1:0] pos;
    growing = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (shadow_count == DEPTH) growing = 1'b0;
      else if (shadow_count == 0) growing = 1'b1;
      else if ($urandom_range(99) < 2) growing = !growing;
      if ($urandom_range(99) < 12) begin
        act = ils_action_t'($urandom_range(3));
        pos = POS_W'($urandom_range(16));
      end else begin
        roll = $urandom_range(99);
        if (roll < (growing ? 45 : 15)) act = ACT_INSERT;
        else if (roll < 60) act = ACT_REMOVE;
        else if (roll < 80) act = ACT_GET;
        else act = ACT_SET;
        if (act == ACT_INSERT) begin
          roll = $urandom_range(9);
          if (roll == 0) pos = '0;
          else if (roll == 1) pos = POS_W'(shadow_count);
          else pos = POS_W'($urandom_range(shadow_count));
        end else if (shadow_count == 0) begin
          pos = '0;
        end else begin
          pos = POS_W'($urandom_range(shadow_count - 1));
        end
      end
      send_request(act, pos, pick_value());
    end
  endtask

  task automatic test_empty_list();
    send_request(ACT_GET,    5'd0, 32'h1234_5678);
    send_request(ACT_REMOVE, 5'd0, 32'h0);
    send_request(ACT_SET,    5'd0, 32'hDEAD_BEEF);
    send_request(ACT_INSERT, 5'd1, 32'hCAFE_F00D);
  endtask

  task automatic test_insert_forms();
    send_request(ACT_INSERT, 5'd0, 32'h0000_0000);
    send_request(ACT_INSERT, 5'd1, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 5'd1, 32'hA5A5_A5A5);
    send_request(ACT_INSERT, 5'd0, 32'h5A5A_5A5A);
    send_request(ACT_INSERT, 5'd5, 32'h1111_1111);
  endtask

  task automatic test_get_set();
    int p;
    for (p = 0; p < 4; p++) send_request(ACT_GET, POS_W'(p), 32'hFFFF_FFFF);
    send_request(ACT_SET, 5'd3, 32'h8000_0001);
    send_request(ACT_GET, 5'd3, 32'h0);
    send_request(ACT_GET, 5'd4, 32'h0);
    send_request(ACT_SET, 5'd4, 32'h7FFF_FFFE);
  endtask

  task automatic test_remove();
    send_request(ACT_REMOVE, 5'd0, 32'hFFFF_FFFF);
    send_request(ACT_REMOVE, 5'd2, 32'h0);
    send_request(ACT_REMOVE, 5'd2, 32'h0);
    send_request(ACT_GET,    5'd0, 32'h0);
    send_request(ACT_GET,    5'd1, 32'h0);
    wait_for_results();
  endtask

  task automatic test_full_store();
    while (shadow_count < DEPTH)
      send_request(ACT_INSERT, POS_W'(shadow_count), pick_value());
    send_request(ACT_INSERT, 5'd16, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 5'd0,  32'hFFFF_FFFF);
    send_request(ACT_GET,    5'd15, 32'h0);
    send_request(ACT_GET,    5'd16, 32'h0);
    send_request(ACT_REMOVE, 5'd15, 32'h0);
    send_request(ACT_INSERT, 5'd15, 32'h0F0F_0F0F);
    send_request(ACT_GET,    5'd15, 32'h0);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = 1'b1;
    run_list_traffic(30);
    wait_for_results();
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct, input int n_items);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    run_list_traffic(n_items);
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: ok=%0b read=%08h count=%0d",
                   m_tdata[0], m_tdata[32:1], m_tdata[37:33]);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[0] !== want.ok || m_tdata[32:1] !== want.read_value ||
            m_tdata[37:33] !== want.item_count) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result %0d mismatch: exp ok=%0b read=%08h count=%0d, got ok=%0b read=%08h count=%0d",
                     results_seen, want.ok, want.read_value, want.item_count,
                     m_tdata[0], m_tdata[32:1], m_tdata[37:33]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_insert_forms();
    test_get_set();
    test_remove();
    test_full_store();
    test_backpressure();
    test_random_phase(0,  0,  270);
    test_random_phase(78, 0,  270);
    test_random_phase(0,  78, 270);
    test_random_phase(16, 16, 270);
    repeat (5) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d rejected (%0d on a full store)",
             requests_sent, results_seen, rejects, full_rejects);
    $display("list depth reached %0d of %0d; %0d mismatches", deepest, DEPTH, fail_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store.sv
rtl/ils_checker.sv
verif/tb_indexed_list_store.sv
